/* rtl/aes_pkg.sv */
`default_nettype none
package aes_pkg;

	typedef logic [127:0] blk_t;
	typedef logic [7:0] rcon_t;

	// Round constant for round r (1..10), indexed from 0.
	function automatic rcon_t rcon(input logic [3:0] idx);
		rcon_t r;
		r = 8'h00;
		case (idx)
			4'd0: r = 8'h01;
			4'd1: r = 8'h02;
			4'd2: r = 8'h04;
			4'd3: r = 8'h08;
			4'd4: r = 8'h10;
			4'd5: r = 8'h20;
			4'd6: r = 8'h40;
			4'd7: r = 8'h80;
			4'd8: r = 8'h1b;
			4'd9: r = 8'h36;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// Multiply by x in GF(2^8).
	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// Forward S-box as a constant table.
	function automatic logic [7:0] sbox(input logic [7:0] x);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return t[x];
	endfunction

endpackage
`default_nettype wire

/* rtl/aes_round.sv */
`default_nettype none
// One round cell: key schedule step and cipher round, registered.
module aes_round #(
	parameter int unsigned RoundIdx = 0,
	parameter bit LastRound = 1'b0
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           vld_in,
	input  wire aes_pkg::blk_t  st_in,
	input  wire aes_pkg::blk_t  key_in,
	output logic                vld_q,
	output aes_pkg::blk_t       st_q,
	output aes_pkg::blk_t       key_q
);

	logic [7:0] b [16];
	logic [7:0] sb [16];
	logic [7:0] mc [16];
	logic [7:0] kb [16];
	logic [7:0] nk [16];
	aes_pkg::blk_t st_d;
	aes_pkg::blk_t key_d;

	// Byte views, byte 0 at the top.
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			b[i] = st_in[127 - 8*i -: 8];
			kb[i] = key_in[127 - 8*i -: 8];
		end
	end

	// SubBytes with ShiftRows.
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				sb[c*4 + r] = aes_pkg::sbox(b[((c + r) % 4)*4 + r]);
			end
		end
	end

	// MixColumns.
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			mc[c*4+0] = aes_pkg::xtime(sb[c*4]) ^ aes_pkg::xtime(sb[c*4+1]) ^ sb[c*4+1]
				^ sb[c*4+2] ^ sb[c*4+3];
			mc[c*4+1] = sb[c*4] ^ aes_pkg::xtime(sb[c*4+1]) ^ aes_pkg::xtime(sb[c*4+2])
				^ sb[c*4+2] ^ sb[c*4+3];
			mc[c*4+2] = sb[c*4] ^ sb[c*4+1] ^ aes_pkg::xtime(sb[c*4+2])
				^ aes_pkg::xtime(sb[c*4+3]) ^ sb[c*4+3];
			mc[c*4+3] = aes_pkg::xtime(sb[c*4]) ^ sb[c*4] ^ sb[c*4+1] ^ sb[c*4+2]
				^ aes_pkg::xtime(sb[c*4+3]);
		end
	end

	// Next round key.
	always_comb begin
		nk[0] = kb[0] ^ aes_pkg::sbox(kb[13]) ^ aes_pkg::rcon(4'(RoundIdx));
		nk[1] = kb[1] ^ aes_pkg::sbox(kb[14]);
		nk[2] = kb[2] ^ aes_pkg::sbox(kb[15]);
		nk[3] = kb[3] ^ aes_pkg::sbox(kb[12]);
		for (int i = 4; i < 16; i++) begin
			nk[i] = kb[i] ^ nk[i-4];
		end
		for (int i = 0; i < 16; i++) begin
			key_d[127 - 8*i -: 8] = nk[i];
			st_d[127 - 8*i -: 8] = (LastRound ? sb[i] : mc[i]) ^ nk[i];
		end
	end

	// Valid flag of this stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	// Payload of this stage.
	always_ff @(posedge clk) begin
		if (en) begin
			st_q <= st_d;
			key_q <= key_d;
		end
	end

endmodule
`default_nettype wire

/* rtl/aes128_block_encrypt.sv */
`default_nettype none
// Input stage loads at the transfer, then the round cells in order, to result valid.
// Throughput: one block per cycle unless stalled; each cell holds a different block.
// The chain advances whenever the last stage is empty or its result is taken.
// Reset clears all valid flags; payload registers are not reset.
module aes128_block_encrypt (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [63:0] key_high,
	input  wire logic [63:0] key_low,
	input  wire logic [63:0] text_high,
	input  wire logic [63:0] text_low,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      cipher_high,
	output logic [63:0]      cipher_low
);

	logic          vld [11];
	aes_pkg::blk_t st [11];
	aes_pkg::blk_t key [11];
	logic          en;

	// Whole chain moves together when the output slot frees.
	assign en = !vld[10] || out_ready;
	assign in_ready = en;

	// Initial key addition stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld[0] <= 1'b0;
		end else if (en) begin
			vld[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st[0] <= {text_high, text_low} ^ {key_high, key_low};
			key[0] <= {key_high, key_low};
		end
	end

	// Ten round cells.
	for (genvar g = 0; g < 10; g++) begin : g_round
		aes_round #(
			.RoundIdx(g),
			.LastRound(g == 9)
		) u_round (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.vld_in(vld[g]),
			.st_in(st[g]),
			.key_in(key[g]),
			.vld_q(vld[g+1]),
			.st_q(st[g+1]),
			.key_q(key[g+1])
		);
	end

	assign out_valid = vld[10];
	assign cipher_high = st[10][127:64];
	assign cipher_low = st[10][63:0];

endmodule
`default_nettype wire
